[sv/vfpa_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vfpa_pkg
// Shared types, constants and helper functions of the point advection unit.
// ----------------------------------------------------------------------------
package vfpa_pkg;

  localparam int FRAC_BITS = 24;
  localparam int TS_W      = 24;
  localparam int LIM_W     = 7;
  localparam int CFG_W     = 24;
  localparam int IDX_W     = 2;
  localparam int POS_W     = 32;

  localparam logic [IDX_W-1:0] REG_STEP_LEN = 2'd0;
  localparam logic [IDX_W-1:0] REG_X_LIMIT  = 2'd1;
  localparam logic [IDX_W-1:0] REG_Y_LIMIT  = 2'd2;

  localparam logic [TS_W-1:0]  STEP_LEN_RST = 24'd167772;
  localparam logic [LIM_W-1:0] LIMIT_RST    = 7'd82;

  // angle reduction word, unsigned Q30 plus offset
  localparam int UW = 39;
  localparam logic [UW-1:0] TWO_PI_U    = 39'd6746518852;
  localparam logic [UW-1:0] WRAP_OFFSET = TWO_PI_U << 5;

  // cordic datapath, signed Q30
  localparam int AW = 35;
  localparam logic signed [AW-1:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [AW-1:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [AW-1:0] TWO_PI_Q30  = 35'sd6746518852;
  localparam logic signed [AW-1:0] GAIN_Q30    = 35'sd652032874;

  localparam int CORDIC_STAGES = 14;
  localparam int ATAN_HEAD_N   = 10;

  localparam logic signed [AW-1:0] ATAN_HEAD [ATAN_HEAD_N] = '{
    35'sd843314856, 35'sd497837829, 35'sd263043836, 35'sd133525158, 35'sd67021686,
    35'sd33543515,  35'sd16775850,  35'sd8388437,   35'sd4194282,   35'sd2097149
  };

  localparam int SW = 40;
  localparam logic signed [SW-1:0] SAT_MAX = 40'sd2147483647;
  localparam logic signed [SW-1:0] SAT_MIN = -40'sd2147483648;

  typedef struct packed {
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic                    dead;
  } part_t;

  typedef struct packed {
    logic signed [AW-1:0] x;
    logic signed [AW-1:0] y;
    logic signed [AW-1:0] z;
  } rot_t;

  typedef struct packed {
    part_t p;
    rot_t  rx;
    rot_t  ry;
    logic  fx;
    logic  fy;
  } cord_t;

  typedef struct packed {
    part_t                p;
    logic signed [AW-1:0] cos_y;
    logic signed [AW-1:0] sin_x;
  } trig_t;

  typedef struct packed {
    logic signed [POS_W-1:0] new_x;
    logic signed [POS_W-1:0] new_y;
    logic signed [POS_W-1:0] vel_x;
    logic signed [POS_W-1:0] vel_y;
    logic                    dead;
  } res_t;

  function automatic logic signed [AW-1:0] atan_q30(int i);
    logic [3:0] idx;
    idx = i[3:0];
    if (i < ATAN_HEAD_N) return ATAN_HEAD[idx];
    return AW'((64'sd1 <<< (30 - i)) - 64'sd1);
  endfunction

  function automatic rot_t cordic_iter(rot_t a, int i);
    rot_t r;
    logic signed [AW-1:0] sx;
    logic signed [AW-1:0] sy;
    logic signed [AW-1:0] at;
    sx = a.x >>> i;
    sy = a.y >>> i;
    at = atan_q30(i);
    if (!a.z[AW-1]) begin
      r.x = a.x - sy;
      r.y = a.y + sx;
      r.z = a.z - at;
    end else begin
      r.x = a.x + sy;
      r.y = a.y - sx;
      r.z = a.z + at;
    end
    return r;
  endfunction

  function automatic logic signed [POS_W-1:0] sat32(logic signed [SW-1:0] v);
    if (v > SAT_MAX) return SAT_MAX[POS_W-1:0];
    if (v < SAT_MIN) return SAT_MIN[POS_W-1:0];
    return v[POS_W-1:0];
  endfunction

endpackage
`default_nettype wire

[sv/vfpa_reduce.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vfpa_reduce
// Five-stage angle reduction of both coordinates into [-pi/2, pi/2] plus fold.
// ----------------------------------------------------------------------------
module vfpa_reduce (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            up_valid,
  output logic                 up_stall,
  input  vfpa_pkg::part_t      up_item,
  output logic                 dn_valid,
  input  wire logic            dn_stall,
  output vfpa_pkg::cord_t      dn_item
);
  import vfpa_pkg::*;

  typedef struct packed {
    part_t          p;
    logic [UW-1:0]  ux;
    logic [UW-1:0]  uy;
  } red_t;

  typedef struct packed {
    logic signed [AW-1:0] z;
    logic                 flip;
  } fold_t;

  function automatic logic [UW-1:0] sub_if(logic [UW-1:0] u, logic [UW-1:0] k);
    return (u >= k) ? u - k : u;
  endfunction

  function automatic logic [UW-1:0] widen(logic signed [POS_W-1:0] a);
    logic signed [UW-1:0] w;
    w = UW'(a);
    return UW'(w <<< (30 - FRAC_BITS)) + WRAP_OFFSET;
  endfunction

  function automatic fold_t fold(logic [UW-1:0] r);
    fold_t f;
    f.z    = AW'(r);
    f.flip = 1'b0;
    if (f.z > PI_Q30) f.z = f.z - TWO_PI_Q30;
    if (f.z > HALF_PI_Q30) begin
      f.z    = f.z - PI_Q30;
      f.flip = 1'b1;
    end else if (f.z < -HALF_PI_Q30) begin
      f.z    = f.z + PI_Q30;
      f.flip = 1'b1;
    end
    return f;
  endfunction

  localparam int NS = 5;

  logic [NS-1:0] v_r;
  logic [NS-1:0] en;
  red_t  s0_r, s1_r, s2_r, s3_r;
  red_t  s0_nxt, s1_nxt, s2_nxt, s3_nxt;
  cord_t out_r, out_nxt;
  fold_t fx, fy;

  always_comb begin
    en[NS-1] = !v_r[NS-1] || !dn_stall;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign up_stall = !en[0];
  assign dn_valid = v_r[NS-1];
  assign dn_item  = out_r;

  always_comb begin
    s0_nxt.p  = up_item;
    s0_nxt.ux = widen(up_item.px);
    s0_nxt.uy = widen(up_item.py);

    s1_nxt    = s0_r;
    s1_nxt.ux = sub_if(sub_if(s0_r.ux, TWO_PI_U << 5), TWO_PI_U << 4);
    s1_nxt.uy = sub_if(sub_if(s0_r.uy, TWO_PI_U << 5), TWO_PI_U << 4);

    s2_nxt    = s1_r;
    s2_nxt.ux = sub_if(sub_if(s1_r.ux, TWO_PI_U << 3), TWO_PI_U << 2);
    s2_nxt.uy = sub_if(sub_if(s1_r.uy, TWO_PI_U << 3), TWO_PI_U << 2);

    s3_nxt    = s2_r;
    s3_nxt.ux = sub_if(sub_if(s2_r.ux, TWO_PI_U << 1), TWO_PI_U);
    s3_nxt.uy = sub_if(sub_if(s2_r.uy, TWO_PI_U << 1), TWO_PI_U);

    fx = fold(s3_r.ux);
    fy = fold(s3_r.uy);
    out_nxt.p    = s3_r.p;
    out_nxt.rx.x = GAIN_Q30;
    out_nxt.rx.y = '0;
    out_nxt.rx.z = fx.z;
    out_nxt.ry.x = GAIN_Q30;
    out_nxt.ry.y = '0;
    out_nxt.ry.z = fy.z;
    out_nxt.fx   = fx.flip;
    out_nxt.fy   = fy.flip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= up_valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) s0_r  <= s0_nxt;
    if (en[1]) s1_r  <= s1_nxt;
    if (en[2]) s2_r  <= s2_nxt;
    if (en[3]) s3_r  <= s3_nxt;
    if (en[4]) out_r <= out_nxt;
  end

endmodule
`default_nettype wire

[sv/vfpa_cordic.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vfpa_cordic
// Rotation-mode cordic for both lanes, two iterations per register stage.
// ----------------------------------------------------------------------------
module vfpa_cordic (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            up_valid,
  output logic                 up_stall,
  input  vfpa_pkg::cord_t      up_item,
  output logic                 dn_valid,
  input  wire logic            dn_stall,
  output vfpa_pkg::trig_t      dn_item
);
  import vfpa_pkg::*;

  localparam int NS = CORDIC_STAGES;

  logic  [NS-1:0] v_r;
  logic  [NS-1:0] en;
  cord_t          st_r [NS];

  always_comb begin
    en[NS-1] = !v_r[NS-1] || !dn_stall;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign up_stall      = !en[0];
  assign dn_valid      = v_r[NS-1];
  assign dn_item.p     = st_r[NS-1].p;
  assign dn_item.cos_y = st_r[NS-1].ry.x;
  assign dn_item.sin_x = st_r[NS-1].rx.y;

  for (genvar s = 0; s < NS; s++) begin : g_stage
    cord_t prv;
    cord_t st_nxt;

    if (s == 0) begin : g_first
      assign prv = up_item;
    end else begin : g_rest
      assign prv = st_r[s-1];
    end

    always_comb begin
      st_nxt    = prv;
      st_nxt.rx = cordic_iter(cordic_iter(prv.rx, 2 * s), 2 * s + 1);
      st_nxt.ry = cordic_iter(cordic_iter(prv.ry, 2 * s), 2 * s + 1);
      // undo the half-turn fold on the way out
      if (s == NS - 1) begin
        if (prv.fx) begin
          st_nxt.rx.x = -st_nxt.rx.x;
          st_nxt.rx.y = -st_nxt.rx.y;
        end
        if (prv.fy) begin
          st_nxt.ry.x = -st_nxt.ry.x;
          st_nxt.ry.y = -st_nxt.ry.y;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) st_r[s] <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= up_valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

endmodule
`default_nettype wire

[sv/vfpa_euler.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vfpa_euler
// Velocity products, Euler step, saturation and the kill test; five stages.
// ----------------------------------------------------------------------------
module vfpa_euler (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [vfpa_pkg::TS_W-1:0]  step_len,
  input  wire logic [vfpa_pkg::LIM_W-1:0] x_limit,
  input  wire logic [vfpa_pkg::LIM_W-1:0] y_limit,
  input  wire logic                       up_valid,
  output logic                            up_stall,
  input  vfpa_pkg::trig_t                 up_item,
  output logic                            dn_valid,
  input  wire logic                       dn_stall,
  output vfpa_pkg::res_t                  dn_item
);
  import vfpa_pkg::*;

  localparam int PW = POS_W + AW;
  localparam int MW = POS_W + TS_W + 1;
  localparam int NS = 5;
  localparam int LW = LIM_W + FRAC_BITS + 2;

  localparam logic signed [PW-1:0] PROD_HALF = PW'(64'sd1 <<< 29);
  localparam logic signed [MW-1:0] STEP_HALF = MW'(64'sd1 <<< (TS_W - 1));

  typedef struct packed {
    part_t                p;
    logic signed [PW-1:0] prod_x;
    logic signed [PW-1:0] prod_y;
  } e0_t;

  typedef struct packed {
    part_t                   p;
    logic signed [POS_W-1:0] vx;
    logic signed [POS_W-1:0] vy;
  } e1_t;

  typedef struct packed {
    part_t                   p;
    logic signed [POS_W-1:0] vx;
    logic signed [POS_W-1:0] vy;
    logic signed [MW-1:0]    mx;
    logic signed [MW-1:0]    my;
  } e2_t;

  typedef struct packed {
    part_t                   p;
    logic signed [POS_W-1:0] vx;
    logic signed [POS_W-1:0] vy;
    logic signed [POS_W-1:0] nx;
    logic signed [POS_W-1:0] ny;
  } e3_t;

  logic [NS-1:0] v_r;
  logic [NS-1:0] en;
  e0_t  e0_r, e0_nxt;
  e1_t  e1_r, e1_nxt;
  e2_t  e2_r, e2_nxt;
  e3_t  e3_r, e3_nxt;
  res_t out_r, out_nxt;

  logic signed [PW-1:0]    tx, ty;
  logic signed [MW-1:0]    sx, sy;
  logic signed [TS_W:0]    ts_s;
  logic signed [LW-1:0]    ax, ay, lim_x, lim_y;
  logic                    kill;

  always_comb begin
    en[NS-1] = !v_r[NS-1] || !dn_stall;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign up_stall = !en[0];
  assign dn_valid = v_r[NS-1];
  assign dn_item  = out_r;

  always_comb begin
    // vx from y and cos(y), vy from x and sin(x)
    e0_nxt.p      = up_item.p;
    e0_nxt.prod_x = PW'(up_item.p.py) * PW'(up_item.cos_y);
    e0_nxt.prod_y = PW'(up_item.p.px) * PW'(up_item.sin_x);

    tx        = (e0_r.prod_x + PROD_HALF) >>> 30;
    ty        = (e0_r.prod_y + PROD_HALF) >>> 30;
    e1_nxt.p  = e0_r.p;
    e1_nxt.vx = sat32(-SW'(tx));
    e1_nxt.vy = sat32(-SW'(ty));

    ts_s      = $signed({1'b0, step_len});
    e2_nxt.p  = e1_r.p;
    e2_nxt.vx = e1_r.vx;
    e2_nxt.vy = e1_r.vy;
    e2_nxt.mx = MW'(e1_r.vx) * MW'(ts_s);
    e2_nxt.my = MW'(e1_r.vy) * MW'(ts_s);

    sx        = (e2_r.mx + STEP_HALF) >>> TS_W;
    sy        = (e2_r.my + STEP_HALF) >>> TS_W;
    e3_nxt.p  = e2_r.p;
    e3_nxt.vx = e2_r.vx;
    e3_nxt.vy = e2_r.vy;
    e3_nxt.nx = sat32(SW'(e2_r.p.px) + SW'(sx));
    e3_nxt.ny = sat32(SW'(e2_r.p.py) + SW'(sy));

    // true magnitude against limit in position format
    ax    = e3_r.nx[POS_W-1] ? -LW'(e3_r.nx) : LW'(e3_r.nx);
    ay    = e3_r.ny[POS_W-1] ? -LW'(e3_r.ny) : LW'(e3_r.ny);
    lim_x = LW'({x_limit, {FRAC_BITS{1'b0}}});
    lim_y = LW'({y_limit, {FRAC_BITS{1'b0}}});
    kill  = (ax > lim_x) || (ay > lim_y);

    if (e3_r.p.dead) begin
      out_nxt.new_x = e3_r.p.px;
      out_nxt.new_y = e3_r.p.py;
      out_nxt.vel_x = '0;
      out_nxt.vel_y = '0;
      out_nxt.dead  = 1'b1;
    end else begin
      out_nxt.new_x = e3_r.nx;
      out_nxt.new_y = e3_r.ny;
      out_nxt.vel_x = kill ? '0 : e3_r.vx;
      out_nxt.vel_y = kill ? '0 : e3_r.vy;
      out_nxt.dead  = kill;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= up_valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) e0_r  <= e0_nxt;
    if (en[1]) e1_r  <= e1_nxt;
    if (en[2]) e2_r  <= e2_nxt;
    if (en[3]) e3_r  <= e3_nxt;
    if (en[4]) out_r <= out_nxt;
  end

endmodule
`default_nettype wire

[sv/vector_field_point_advect_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vector_field_point_advect_unit
// One Euler step of a particle through v = (-y cos y, -x sin x), Q8.24.
// ----------------------------------------------------------------------------
// Takes one particle word per cycle while in_stall is low and returns its
// advected word through 5 stages of angle reduction, 14 stages of cordic (two
// iterations a stage, 28 in all) and 5 stages of multiply, step, saturate and
// kill test. The pipeline is elastic: empty stages close up under out_stall,
// so in_stall rises only once every stage holds a word. Write the registers
// only while the pipeline is empty.
module vector_field_point_advect_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [vfpa_pkg::IDX_W-1:0]    cfg_index,
  input  wire logic [vfpa_pkg::CFG_W-1:0]    cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [31:0]            in_pos_x,
  input  wire logic signed [31:0]            in_pos_y,
  input  wire logic                          in_dead_in,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [31:0]                 out_new_x,
  output logic signed [31:0]                 out_new_y,
  output logic signed [31:0]                 out_vel_x,
  output logic signed [31:0]                 out_vel_y,
  output logic                               out_dead_out
);
  import vfpa_pkg::*;

  logic [TS_W-1:0]  step_len_r;
  logic [LIM_W-1:0] x_limit_r;
  logic [LIM_W-1:0] y_limit_r;

  part_t in_item;
  cord_t red_item;
  trig_t trig_item;
  res_t  res_item;
  logic  red_valid, red_stall, trig_valid, trig_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_len_r <= STEP_LEN_RST;
      x_limit_r  <= LIMIT_RST;
      y_limit_r  <= LIMIT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_STEP_LEN: step_len_r <= cfg_wdata[TS_W-1:0];
        REG_X_LIMIT:  x_limit_r  <= cfg_wdata[LIM_W-1:0];
        REG_Y_LIMIT:  y_limit_r  <= cfg_wdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_item.px   = in_pos_x;
  assign in_item.py   = in_pos_y;
  assign in_item.dead = in_dead_in;

  vfpa_reduce u_reduce (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_stall (in_stall),
    .up_item  (in_item),
    .dn_valid (red_valid),
    .dn_stall (red_stall),
    .dn_item  (red_item)
  );

  vfpa_cordic u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (red_valid),
    .up_stall (red_stall),
    .up_item  (red_item),
    .dn_valid (trig_valid),
    .dn_stall (trig_stall),
    .dn_item  (trig_item)
  );

  vfpa_euler u_euler (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_len  (step_len_r),
    .x_limit   (x_limit_r),
    .y_limit   (y_limit_r),
    .up_valid  (trig_valid),
    .up_stall  (trig_stall),
    .up_item   (trig_item),
    .dn_valid  (out_valid),
    .dn_stall  (out_stall),
    .dn_item   (res_item)
  );

  assign out_new_x    = res_item.new_x;
  assign out_new_y    = res_item.new_y;
  assign out_vel_x    = res_item.vel_x;
  assign out_vel_y    = res_item.vel_y;
  assign out_dead_out = res_item.dead;

endmodule
`default_nettype wire

[sv/vfpa_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vfpa_checker
// Port-level checks on the result channel of the advection unit.
// ----------------------------------------------------------------------------
module vfpa_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_new_x,
  input wire logic [31:0] out_new_y,
  input wire logic [31:0] out_vel_x,
  input wire logic [31:0] out_vel_y,
  input wire logic        out_dead_out
);

  // a stalled word stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped under stall");

  a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_new_x) && $stable(out_new_y) &&
      $stable(out_vel_x) && $stable(out_vel_y) && $stable(out_dead_out))
    else $error("result word changed under stall");

  // dead particles never report motion
  a_dead_still: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dead_out |-> (out_vel_x == 32'd0) && (out_vel_y == 32'd0))
    else $error("dead particle with nonzero velocity");

endmodule

bind vector_field_point_advect_unit vfpa_checker u_vfpa_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_new_x    (out_new_x),
  .out_new_y    (out_new_y),
  .out_vel_x    (out_vel_x),
  .out_vel_y    (out_vel_y),
  .out_dead_out (out_dead_out)
);
`default_nettype wire
